/* src/four_channel_audio_timer_unit_defines.svh */
// Assertion helpers for the audio timer block
`ifndef FOUR_CHANNEL_AUDIO_TIMER_UNIT_DEFINES_SVH
`define FOUR_CHANNEL_AUDIO_TIMER_UNIT_DEFINES_SVH
`define FCAT_ASSERT_IMPL(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("check failed");
`define FCAT_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("assertion failed");
`endif

/* src/fcat_pkg.sv */
package fcat_pkg;
  localparam int NumCh = 4;
  localparam int CntW = 9;
  typedef enum logic [1:0] {
    MODE_TICK = 2'd0, MODE_START = 2'd1, MODE_RESYNC = 2'd2, MODE_RESET34 = 2'd3
  } mode_t;
  typedef enum logic [1:0] {
    REG_AUDCTL = 2'd0, REG_FREQ = 2'd1, REG_CTL = 2'd2, REG_NONE = 2'd3
  } reg_idx_t;
  typedef struct packed {
    logic [1:0] mode;
    logic       base15_pulse;
    logic       base64_pulse;
    logic       hold_upper_timers;
    logic       filter_tick;
    logic [3:0] poly5_bits;
    logic [3:0] poly4_bits;
    logic [3:0] poly9_bits;
    logic [3:0] poly17_bits;
    logic [1:0] resync_events;
  } in_item_t;
  typedef struct packed {
    logic [2:0] timer_edges;
    logic [2:0] irq_requests;
    logic [3:0] level_one;
    logic [3:0] level_two;
    logic [3:0] level_three;
    logic [3:0] level_four;
  } out_item_t;
  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_item_t;
endpackage

/* src/fcat_if.sv */
interface fcat_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* src/four_channel_audio_timer_unit.sv */
// An accepted item's result goes to the output register; the timer update is one
// combinational pass. Throughput: one item per cycle unless the output stalls.
// The output register frees itself when taken, so input and output proceed together.
// Reset (rst, synchronous, active high) clears out_valid, config registers and timer
// state; counters go to 1, as do waves and filter latches.
`include "four_channel_audio_timer_unit_defines.svh"
module four_channel_audio_timer_unit (
  input logic clk,
  input logic rst,
  fcat_if.sink   in_ch,
  fcat_if.sink   cfg_ch,
  fcat_if.source out_ch
);
  logic [7:0]  audctl;
  logic [31:0] freqs, ctls;
  logic [8:0]  cnt [4];
  logic [2:0]  evd [4];
  logic [1:0]  rld [4];
  logic [3:0]  wave;
  logic [1:0]  flat, fsmp;
  logic [1:0]  fdly [2];
  logic        running;
  logic [1:0]  startcd, rpipe;

  logic [8:0]  cnt_next [4];
  logic [2:0]  evd_next [4];
  logic [1:0]  rld_next [4];
  logic [3:0]  wave_next;
  logic [1:0]  flat_next, fsmp_next;
  logic [1:0]  fdly_next [2];
  logic        running_next;
  logic [1:0]  startcd_next, rpipe_next;
  fcat_pkg::out_item_t res;
  logic        out_valid;
  fcat_pkg::in_item_t it;

  wire accept = in_ch.valid & in_ch.ready;
  wire cfg_wr = cfg_ch.valid & cfg_ch.ready;
  wire audctl_wr = cfg_wr &&
                   (fcat_pkg::reg_idx_t'(cfg_ch.payload.index) == fcat_pkg::REG_AUDCTL);
  assign in_ch.ready = ~out_valid | out_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid;
  assign it = in_ch.payload;

  function automatic logic [7:0] fq(input logic [31:0] f, input int i);
    return f[8*i +: 8];
  endfunction
  function automatic logic jn(input logic [7:0] a, input int i);
    return (i < 2) ? a[4] : a[3];
  endfunction
  function automatic logic fst(input logic [7:0] a, input int i);
    unique case (i)
      0: return a[6];
      1: return a[4] & a[6];
      2: return a[5];
      default: return a[3] & a[5];
    endcase
  endfunction
  function automatic logic [8:0] per(input logic [7:0] a, input logic [31:0] f, input int i);
    if ((i == 0 && a[6]) || (i == 2 && a[5])) return {1'b0, fq(f, i)} + 9'd4;
    return {1'b0, fq(f, i)} + 9'd1;
  endfunction

  // tick: clock channels (wave, filter, irq, joined pairs); start, resync, reset34
  always_comb begin
    logic [3:0] ev, rl, ev2;
    logic reloaded, clkin;
    logic [2:0] irq;
    logic [7:0] c;
    logic [3:0] w;
    for (int i = 0; i < 4; i++) begin
      cnt_next[i] = cnt[i]; evd_next[i] = evd[i]; rld_next[i] = rld[i];
    end
    wave_next = wave; flat_next = flat; fsmp_next = fsmp;
    fdly_next[0] = fdly[0]; fdly_next[1] = fdly[1];
    running_next = running; startcd_next = startcd; rpipe_next = rpipe;
    ev = '0; rl = '0; ev2 = '0; irq = '0; reloaded = 1'b0; c = '0; clkin = 1'b0;
    w = '0;
    unique case (fcat_pkg::mode_t'(it.mode))
      fcat_pkg::MODE_TICK: begin
        if (it.filter_tick) begin
          for (int k = 0; k < 2; k++) begin
            if (fdly[k] != 2'd0) begin
              fdly_next[k] = fdly[k] - 2'd1;
              if (fdly[k] == 2'd1) flat_next[k] = fsmp[k];
            end
          end
        end
        for (int i = 0; i < 4; i++) begin
          if (!(it.hold_upper_timers && i >= 2)) begin
            if (evd[i] != 3'd0) begin
              evd_next[i] = evd[i] - 3'd1;
              ev[i] = (evd[i] == 3'd1);
            end
            if (rld[i] != 2'd0) begin
              rld_next[i] = rld[i] - 2'd1;
              rl[i] = (rld[i] == 2'd1);
            end
          end
        end
        // channel events in index order, then counting pass (fast joined lows)
        for (int pass = 0; pass < 2; pass++) begin
          for (int i = 0; i < 4; i++) begin
            if (pass == 0 && i == 0) begin
              // reload and start happen between the two passes; done below
            end
            if ((pass == 0 && ev[i]) || (pass == 1 && ev2[i])) begin
              c = fq(ctls, i + 0) == 8'd0 ? ctls[8*i +: 8] : ctls[8*i +: 8];
              if (c[7] || it.poly5_bits[i]) begin
                if (c[5]) wave_next[i] = ~wave_next[i];
                else if (c[6]) wave_next[i] = it.poly4_bits[i];
                else if (audctl[7]) wave_next[i] = it.poly9_bits[i];
                else wave_next[i] = it.poly17_bits[i];
              end
              if (i == 2 && audctl[2]) begin
                fsmp_next[0] = wave_next[0]; fdly_next[0] = 2'd2;
              end
              if (i == 3 && audctl[1]) begin
                fsmp_next[1] = wave_next[1]; fdly_next[1] = 2'd2;
              end
              if (running) begin
                if (i == 0 && !audctl[4]) irq[0] = 1'b1;
                if (i == 1) irq[1] = 1'b1;
                if (i == 3) irq[2] = 1'b1;
              end
              if ((i == 0 || i == 2) && jn(audctl, i)) begin
                if (cnt_next[i+1] != 9'd0) begin
                  cnt_next[i+1] = cnt_next[i+1] - 9'd1;
                  if (cnt_next[i+1] == 9'd0) evd_next[i+1] = 3'd3;
                end
              end
              if ((i == 1 || i == 3) && jn(audctl, i)) begin
                cnt_next[i-1] = per(audctl, freqs, i - 1);
                cnt_next[i] = {1'b0, fq(freqs, i)} + 9'd1;
              end
            end
            if (pass == 0 && i == 3) begin
              for (int k = 0; k < 4; k++)
                if (rl[k]) cnt_next[k] = {1'b0, fq(freqs, k)} + 9'd1;
              if (startcd != 2'd0) begin
                startcd_next = startcd - 2'd1;
                if (startcd == 2'd1) begin
                  reloaded = 1'b1;
                  for (int k = 0; k < 4; k++) begin
                    if ((jn(audctl, k) && k[0]) || (fst(audctl, k) && !jn(audctl, k)))
                      cnt_next[k] = {1'b0, fq(freqs, k)} + 9'd1;
                    else cnt_next[k] = per(audctl, freqs, k);
                    evd_next[k] = '0; rld_next[k] = '0; wave_next[k] = 1'b1;
                  end
                end
              end
              for (int k = 0; k < 4; k++) begin
                clkin = fst(audctl, k) || (audctl[0] ? it.base15_pulse : it.base64_pulse);
                if (!(it.hold_upper_timers && k >= 2) && !reloaded && !rl[k] && clkin &&
                    !(jn(audctl, k) && k[0])) begin
                  if (fst(audctl, k) && jn(audctl, k)) begin
                    if (cnt_next[k] != 9'd0 && cnt_next[k] != 9'd1)
                      cnt_next[k] = cnt_next[k] - 9'd1;
                    else begin
                      cnt_next[k] = 9'd256; ev2[k] = 1'b1;
                    end
                  end else if (evd_next[k] == 3'd0 && rld_next[k] == 2'd0) begin
                    if (cnt_next[k] != 9'd0 && cnt_next[k] != 9'd1)
                      cnt_next[k] = cnt_next[k] - 9'd1;
                    else if (fst(audctl, k)) begin
                      cnt_next[k] = 9'd0; evd_next[k] = 3'd4; rld_next[k] = 2'd3;
                    end else begin
                      cnt_next[k] = jn(audctl, k) ? 9'd256 : 9'd0;
                      evd_next[k] = 3'd5;
                      if (!jn(audctl, k)) rld_next[k] = 2'd3;
                    end
                  end
                end
              end
            end
          end
        end
        if (rpipe[0]) begin
          for (int k = 0; k < 2; k++) begin
            if (fst(audctl, k) && !jn(audctl, k)) begin
              cnt_next[k] = {1'b0, fq(freqs, k)} + 9'd1; evd_next[k] = 3'd4;
              rld_next[k] = 2'd3;
            end else begin
              cnt_next[k] = per(audctl, freqs, k); evd_next[k] = '0; rld_next[k] = '0;
            end
          end
        end
        rpipe_next = {1'b0, rpipe[1]};
      end
      fcat_pkg::MODE_START: begin
        running_next = 1'b1; startcd_next = 2'd3;
      end
      fcat_pkg::MODE_RESYNC: begin
        if ((it.resync_events[0] && fst(audctl, 0)) ||
            (it.resync_events[1] && fst(audctl, 1))) rpipe_next = rpipe | 2'b10;
        else begin
          for (int k = 0; k < 2; k++) begin
            if (fst(audctl, k) && !jn(audctl, k)) begin
              cnt_next[k] = {1'b0, fq(freqs, k)} + 9'd1; evd_next[k] = 3'd4;
              rld_next[k] = 2'd3;
            end else begin
              cnt_next[k] = per(audctl, freqs, k); evd_next[k] = '0; rld_next[k] = '0;
            end
          end
        end
      end
      default: begin
        for (int k = 2; k < 4; k++) begin
          cnt_next[k] = (jn(audctl, k) && k[0]) ? {1'b0, fq(freqs, k)} + 9'd1
                                                : per(audctl, freqs, k);
          evd_next[k] = '0; rld_next[k] = '0;
        end
      end
    endcase
    w = wave_next ^ {2'b00, flat_next};
    res.timer_edges = (it.mode == fcat_pkg::MODE_TICK) ?
                      {ev[3] | ev2[3], ev[1] | ev2[1], ev[0] | ev2[0]} : 3'd0;
    res.irq_requests = irq;
    res.level_one   = (ctls[4]  || w[0]) ? ctls[3:0]   : 4'd0;
    res.level_two   = (ctls[12] || w[1]) ? ctls[11:8]  : 4'd0;
    res.level_three = (ctls[20] || w[2]) ? ctls[19:16] : 4'd0;
    res.level_four  = (ctls[28] || w[3]) ? ctls[27:24] : 4'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      audctl <= '0; freqs <= '0; ctls <= '0;
      for (int k = 0; k < 4; k++) begin
        cnt[k] <= 9'd1; evd[k] <= '0; rld[k] <= '0;
      end
      wave <= '1; flat <= '1; fsmp <= '0; fdly[0] <= '0; fdly[1] <= '0;
      running <= 1'b0; startcd <= '0; rpipe <= '0;
    end else begin
      if (accept) begin
        out_valid <= 1'b1;
        out_ch.payload <= res;
        for (int k = 0; k < 4; k++) begin
          cnt[k] <= cnt_next[k]; evd[k] <= evd_next[k]; rld[k] <= rld_next[k];
        end
        wave <= wave_next; fsmp <= fsmp_next;
        running <= running_next; startcd <= startcd_next; rpipe <= rpipe_next;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      // a control write that drops a filter enable forces its latch high
      for (int k = 0; k < 2; k++) begin
        if (audctl_wr && !cfg_ch.payload.data[2 - k]) begin
          flat[k] <= 1'b1; fdly[k] <= '0;
        end else if (accept) begin
          flat[k] <= flat_next[k]; fdly[k] <= fdly_next[k];
        end
      end
      if (cfg_wr) begin
        unique case (fcat_pkg::reg_idx_t'(cfg_ch.payload.index))
          fcat_pkg::REG_AUDCTL: audctl <= cfg_ch.payload.data[7:0];
          fcat_pkg::REG_FREQ: freqs <= cfg_ch.payload.data;
          fcat_pkg::REG_CTL: ctls <= cfg_ch.payload.data;
          default: ;
        endcase
      end
    end
  end

  `FCAT_ASSERT_NEXT(a_out_after_accept, clk, rst, accept, out_valid)
  `FCAT_ASSERT_IMPL(a_no_irq_stopped, clk, rst, accept && !running, res.irq_requests == 3'd0)
  `FCAT_ASSERT_IMPL(a_edges_tick_only, clk, rst,
                    accept && it.mode != fcat_pkg::MODE_TICK, res.timer_edges == 3'd0)
endmodule
